FILE: design/byte_ring_buffer_top_macros.svh
// Assertion macros for the byte ring buffer.
// Included by the module that carries concurrent checks; needs clk and arst_n in scope.
`ifndef BYTE_RING_BUFFER_TOP_MACROS_SVH
`define BYTE_RING_BUFFER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BRB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("byte ring buffer: same-cycle check failed");
`define BRB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("byte ring buffer: next-cycle check failed");
`else
`define BRB_ASSERT_IMPL(label, ante, cons)
`define BRB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/brb_pkg.sv
// Shared types and constants of the byte ring buffer.
// No dependencies; imported by the controller, the byte store, the top level and the testbench.
package brb_pkg;

	localparam int CAP_W = 9;
	localparam int DONE_W = 5;
	localparam int BYTE_W = 8;
	localparam int MAX_BURST = 16;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_SKIP = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [BYTE_W-1:0] data_in;
		logic [DONE_W-1:0] burst_count;
		logic start_empty;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_out;
		logic is_last;
		logic [DONE_W-1:0] done_count;
		logic [CAP_W-1:0] readable;
		logic [CAP_W-1:0] writable;
	} out_item_t;

endpackage

FILE: design/byte_ring_buffer_top.sv
// Top level of the byte ring buffer: byte store plus pointer controller.
// Depends on brb_pkg, brb_ram and brb_ctrl.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_ready   in_item_t
//   out      from block out_valid/out_ready out_item_t
//   cfg      to block   cfg_we              cfg_wdata (capacity)
//
// A write, skip, clear or empty read is accepted, then its result is registered.
// A read burst of n bytes is accepted, then each byte gets a read step, then a result
// step fed by the store's registered read port. Requests are handled one at a time.
// Reset clears the pointers and sets capacity to 256; the store itself is not cleared.
// A stalled output holds the controller in its result step until the result is taken.
module byte_ring_buffer_top import brb_pkg::*; #(
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CAP_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);

	logic wr_en;
	logic [$clog2(DEPTH)-1:0] wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic rd_en;
	logic [$clog2(DEPTH)-1:0] rd_addr;
	logic [BYTE_W-1:0] rd_data;

	brb_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	brb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

FILE: design/brb_ram.sv
// Byte store of the ring buffer: one write port, one read port, registered read data.
// Depends on brb_pkg for the byte width.
module brb_ram import brb_pkg::*; #(
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [BYTE_W-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/brb_ctrl.sv
// Pointer and fill tracking, request sequencing and result register of the ring buffer.
// Depends on brb_pkg and the assertion macros; drives the byte store brb_ram.
`include "byte_ring_buffer_top_macros.svh"
module brb_ctrl import brb_pkg::*; #(
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CAP_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	output logic wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [BYTE_W-1:0] wr_data,
	output logic rd_en,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	input logic [BYTE_W-1:0] rd_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = (PW + 1 > CAP_W) ? PW + 1 : CAP_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RD = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_q;
	logic lwr_q;
	logic [CAP_W-1:0] cap_q;
	logic [DONE_W-1:0] remaining_q;
	logic [DONE_W-1:0] done_q;
	logic is_read_q;
	logic out_valid_q;
	out_item_t out_data_q;

	state_t state_d;
	logic [PW-1:0] rp_d;
	logic [PW-1:0] wp_d;
	logic lwr_d;
	logic [CAP_W-1:0] cap_d;
	logic [DONE_W-1:0] remaining_d;
	logic [DONE_W-1:0] done_d;
	logic is_read_d;
	logic out_valid_d;

	logic [CW-1:0] eff_cap;
	logic [CW-1:0] readable;
	logic [CW-1:0] writable;
	logic [CW-1:0] clip_a;
	logic [CW-1:0] burst_n;
	logic [DONE_W-1:0] burst_n_d;
	logic accept;
	logic slot_free;
	logic not_full;

	// Moves a pointer forward by inc entries, wrapping at the effective capacity.
	function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p,
			input logic [CW-1:0] lim, input logic [CW-1:0] inc);
		logic [CW-1:0] s;
		s = CW'(p) + inc;
		if (s >= lim) begin
			s = s - lim;
		end
		return s[PW-1:0];
	endfunction

	assign eff_cap = (CW'(cap_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);

	// Equal pointers mean empty after a read and full after a write.
	always_comb begin
		if (wp_q < rp_q) begin
			readable = eff_cap - CW'(rp_q) + CW'(wp_q);
		end else if (wp_q > rp_q) begin
			readable = CW'(wp_q) - CW'(rp_q);
		end else begin
			readable = lwr_q ? '0 : eff_cap;
		end
	end

	assign writable = eff_cap - readable;
	assign not_full = (readable != eff_cap);

	assign clip_a = (CW'(in_data.burst_count) > CW'(MAX_BURST)) ? CW'(MAX_BURST)
		: CW'(in_data.burst_count);
	assign burst_n = (clip_a > readable) ? readable : clip_a;
	assign burst_n_d = burst_n[DONE_W-1:0];

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign wr_en = accept && (in_data.opcode == OP_WRITE) && not_full;
	assign wr_addr = wp_q;
	assign wr_data = in_data.data_in;
	assign rd_en = (state_q == ST_RD);
	assign rd_addr = rp_q;

	always_comb begin
		state_d = state_q;
		rp_d = rp_q;
		wp_d = wp_q;
		lwr_d = lwr_q;
		cap_d = cap_q;
		remaining_d = remaining_q;
		done_d = done_q;
		is_read_d = is_read_q;
		out_valid_d = out_valid_q && !out_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					remaining_d = '0;
					is_read_d = 1'b0;
					done_d = '0;
					state_d = ST_EMIT;
					unique case (in_data.opcode)
						OP_WRITE: begin
							if (not_full) begin
								wp_d = step_ptr(wp_q, eff_cap, CW'(1));
								lwr_d = 1'b0;
								done_d = DONE_W'(1);
							end
						end
						OP_READ: begin
							if (burst_n_d != '0) begin
								done_d = burst_n_d;
								remaining_d = burst_n_d;
								is_read_d = 1'b1;
								state_d = ST_RD;
							end
						end
						OP_SKIP: begin
							if (burst_n_d != '0) begin
								rp_d = step_ptr(rp_q, eff_cap, burst_n);
								lwr_d = 1'b1;
								done_d = burst_n_d;
							end
						end
						OP_CLEAR: begin
							rp_d = '0;
							wp_d = '0;
							lwr_d = in_data.start_empty;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RD: begin
				// The store is read at the old pointer; the byte shows up next cycle.
				rp_d = step_ptr(rp_q, eff_cap, CW'(1));
				lwr_d = 1'b1;
				remaining_d = remaining_q - DONE_W'(1);
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					state_d = (remaining_q == '0) ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cfg_we) begin
			cap_d = cfg_wdata;
			rp_d = '0;
			wp_d = '0;
			lwr_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rp_q <= '0;
			wp_q <= '0;
			lwr_q <= 1'b1;
			cap_q <= CAP_W'(256);
			remaining_q <= '0;
			done_q <= '0;
			is_read_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rp_q <= rp_d;
			wp_q <= wp_d;
			lwr_q <= lwr_d;
			cap_q <= cap_d;
			remaining_q <= remaining_d;
			done_q <= done_d;
			is_read_q <= is_read_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			out_data_q.data_out <= is_read_q ? rd_data : '0;
			out_data_q.is_last <= (remaining_q == '0);
			out_data_q.done_count <= done_q;
			out_data_q.readable <= readable[CAP_W-1:0];
			out_data_q.writable <= writable[CAP_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	`BRB_ASSERT_IMPL(a_zero_cap_ptrs, eff_cap == '0, rp_q == '0 && wp_q == '0)
	`BRB_ASSERT_IMPL(a_ptr_range, eff_cap != '0, CW'(rp_q) < eff_cap && CW'(wp_q) < eff_cap)
	`BRB_ASSERT_IMPL(a_rd_pending, state_q == ST_RD, is_read_q && remaining_q != '0)
	`BRB_ASSERT_IMPL(a_burst_progress, state_q == ST_EMIT && is_read_q, remaining_q < done_q)
	`BRB_ASSERT_NEXT(a_emit_pushes, state_q == ST_EMIT && slot_free, out_valid_q)

endmodule

FILE: sim/tb_byte_ring_buffer_top.sv
// Self-checking testbench for byte_ring_buffer_top: directed and random requests under stalls.
// Depends on brb_pkg and the byte ring buffer RTL; the expected results come from a predictor
// kept in this file.
module tb_byte_ring_buffer_top;
	import brb_pkg::*;

	localparam int DEPTH = 256;
	localparam int RESET_CAPACITY = 256;
	localparam int PHASE_ITEMS = 22;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int TAIL_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum {READY_ALWAYS, READY_MOSTLY, READY_PERIODIC, READY_SPARSE} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	// Mirror of the buffer contents and pointers.
	logic [BYTE_W-1:0] ring_store [DEPTH];
	bit ring_written [DEPTH];
	int unsigned rd_ptr = 0;
	int unsigned wr_ptr = 0;
	bit last_op_read = 1'b1;
	int unsigned ring_capacity = RESET_CAPACITY;
	out_item_t expected_results [$];
	out_item_t expected_head;

	int unsigned errors = 0;
	int unsigned requests_sent = 0;
	int unsigned results_checked = 0;
	int unsigned burst_left = 0;
	bit steady_send = 1'b0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int unsigned mode_left = 0;
	int unsigned ready_phase = 0;

	byte_ring_buffer_top #(.DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned usable_depth();
		return (ring_capacity > DEPTH) ? DEPTH : ring_capacity;
	endfunction

	function automatic int unsigned bytes_held();
		if (wr_ptr < rd_ptr) return usable_depth() - rd_ptr + wr_ptr;
		if (wr_ptr > rd_ptr) return wr_ptr - rd_ptr;
		return last_op_read ? 0 : usable_depth();
	endfunction

	function automatic int unsigned step_ptr(input int unsigned p);
		return (p + 1 >= usable_depth()) ? 0 : p + 1;
	endfunction

	function automatic bit store_filled();
		for (int unsigned i = 0; i < usable_depth(); i++) begin
			if (!ring_written[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void push_result(input logic [BYTE_W-1:0] data, input logic last,
			input int unsigned done);
		out_item_t res;
		res.data_out = data;
		res.is_last = last;
		res.done_count = DONE_W'(done);
		res.readable = CAP_W'(bytes_held());
		res.writable = CAP_W'(usable_depth() - bytes_held());
		expected_results.push_back(res);
	endfunction

	function automatic void predict_request(input in_item_t req);
		int unsigned count;
		logic [BYTE_W-1:0] byte_read;
		case (req.opcode)
			OP_WRITE: begin
				if (bytes_held() < usable_depth()) begin
					ring_store[wr_ptr] = req.data_in;
					ring_written[wr_ptr] = 1'b1;
					wr_ptr = step_ptr(wr_ptr);
					last_op_read = 1'b0;
					push_result('0, 1'b1, 1);
				end else begin
					push_result('0, 1'b1, 0);
				end
			end
			OP_CLEAR: begin
				rd_ptr = 0;
				wr_ptr = 0;
				last_op_read = req.start_empty;
				push_result('0, 1'b1, 0);
			end
			default: begin
				count = (req.burst_count > MAX_BURST) ? MAX_BURST : req.burst_count;
				if (count > bytes_held()) count = bytes_held();
				if (count == 0) begin
					push_result('0, 1'b1, 0);
				end else if (req.opcode == OP_SKIP) begin
					repeat (count) rd_ptr = step_ptr(rd_ptr);
					last_op_read = 1'b1;
					push_result('0, 1'b1, count);
				end else begin
					for (int unsigned i = 0; i < count; i++) begin
						byte_read = ring_store[rd_ptr];
						rd_ptr = step_ptr(rd_ptr);
						last_op_read = 1'b1;
						push_result(byte_read, i + 1 == count, count);
					end
				end
			end
		endcase
	endfunction

	function automatic in_item_t make_op(input logic [1:0] op, input logic [BYTE_W-1:0] data,
			input logic [DONE_W-1:0] count, input logic empty);
		in_item_t req;
		req.opcode = op;
		req.data_in = data;
		req.burst_count = count;
		req.start_empty = empty;
		return req;
	endfunction

	function automatic in_item_t random_request(input int unsigned write_pct);
		in_item_t req;
		int unsigned pick;
		req.data_in = BYTE_W'($urandom_range(0, 255));
		req.burst_count = ($urandom_range(0, 3) == 0) ? DONE_W'($urandom_range(0, 31))
			: DONE_W'($urandom_range(1, MAX_BURST));
		req.start_empty = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < write_pct) req.opcode = OP_WRITE;
		else if (pick < write_pct + (100 - write_pct) * 60 / 100) req.opcode = OP_READ;
		else if (pick < write_pct + (100 - write_pct) * 85 / 100) req.opcode = OP_SKIP;
		else req.opcode = OP_CLEAR;
		// A full start is only allowed once every entry in use holds a written byte.
		if (req.opcode == OP_CLEAR && !req.start_empty && !store_filled())
			req.start_empty = 1'b1;
		return req;
	endfunction

	task automatic send_request(input in_item_t req);
		int unsigned gap;
		if (!steady_send && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left != 0) burst_left--;
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!(in_valid && in_ready));
		predict_request(req);
		requests_sent++;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_capacity(input int unsigned value);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= CAP_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		ring_capacity = value;
		rd_ptr = 0;
		wr_ptr = 0;
		last_op_read = 1'b1;
	endtask

	task automatic test_directed();
		// Reset capacity, buffer empty.
		send_request(make_op(OP_READ, 8'h00, 5'd5, 1'b0));
		send_request(make_op(OP_SKIP, 8'hff, 5'd3, 1'b1));
		send_request(make_op(OP_WRITE, 8'h00, 5'd0, 1'b0));
		send_request(make_op(OP_WRITE, 8'hff, 5'd31, 1'b1));
		send_request(make_op(OP_READ, 8'h00, 5'd31, 1'b0));
		send_request(make_op(OP_CLEAR, 8'h00, 5'd0, 1'b1));

		set_capacity(4);
		send_request(make_op(OP_WRITE, 8'ha5, 5'd0, 1'b0));
		send_request(make_op(OP_WRITE, 8'h5a, 5'd0, 1'b0));
		send_request(make_op(OP_WRITE, 8'h01, 5'd0, 1'b0));
		send_request(make_op(OP_WRITE, 8'h80, 5'd0, 1'b0));
		send_request(make_op(OP_WRITE, 8'h33, 5'd0, 1'b0));
		send_request(make_op(OP_READ, 8'h00, 5'd0, 1'b0));
		send_request(make_op(OP_READ, 8'h00, 5'd17, 1'b0));
		send_request(make_op(OP_WRITE, 8'hc3, 5'd0, 1'b0));
		send_request(make_op(OP_WRITE, 8'h3c, 5'd0, 1'b0));
		send_request(make_op(OP_WRITE, 8'h7e, 5'd0, 1'b0));
		send_request(make_op(OP_SKIP, 8'h00, 5'd2, 1'b0));
		send_request(make_op(OP_READ, 8'h00, 5'd16, 1'b0));
		send_request(make_op(OP_CLEAR, 8'h00, 5'd0, 1'b0));
		send_request(make_op(OP_READ, 8'h00, 5'd31, 1'b0));
		send_request(make_op(OP_CLEAR, 8'h00, 5'd0, 1'b1));

		// With no entries in use nothing moves and both counts stay at zero.
		set_capacity(0);
		send_request(make_op(OP_WRITE, 8'h99, 5'd0, 1'b0));
		send_request(make_op(OP_READ, 8'h00, 5'd16, 1'b0));
		send_request(make_op(OP_CLEAR, 8'h00, 5'd0, 1'b0));
		send_request(make_op(OP_SKIP, 8'h00, 5'd31, 1'b0));

		set_capacity(511);
		send_request(make_op(OP_WRITE, 8'he7, 5'd0, 1'b0));
		send_request(make_op(OP_READ, 8'h00, 5'd1, 1'b0));
	endtask

	task automatic test_random_phases();
		int unsigned caps [10] = '{1, 2, 3, 5, 8, 16, 17, 0, 0, 256};
		caps[7] = $urandom_range(4, 40);
		caps[8] = $urandom_range(0, 511);
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			// Mostly writes first, then mostly reads, to push toward the full and the empty edges.
			repeat (PHASE_ITEMS / 2) send_request(random_request(70));
			repeat (PHASE_ITEMS / 2) send_request(random_request(35));
		end
	endtask

	task automatic test_output_stall();
		set_capacity(16);
		steady_send = 1'b1;
		hold_request = HOLD_OFF_CYCLES;
		repeat (40) send_request(random_request(60));
		steady_send = 1'b0;
		wait_for_results();
	endtask

	// Every accepted result is compared with the oldest expected one.
	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request waiting: %p", out_data);
				errors++;
			end else begin
				expected_head = expected_results.pop_front();
				check_field("data_out", expected_head.data_out, out_data.data_out);
				check_field("is_last", expected_head.is_last, out_data.is_last);
				check_field("done_count", expected_head.done_count, out_data.done_count);
				check_field("readable", expected_head.readable, out_data.readable);
				check_field("writable", expected_head.writable, out_data.writable);
				results_checked++;
			end
		end
	end

	// The receiver switches among random stall patterns.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 120);
		end
		mode_left--;
		ready_phase++;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (ready_mode)
				READY_ALWAYS: out_ready <= 1'b1;
				READY_MOSTLY: out_ready <= ($urandom_range(0, 99) < 70);
				READY_PERIODIC: out_ready <= (ready_phase % 5 != 0);
				default: out_ready <= ($urandom_range(0, 99) < 25);
			endcase
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("byte_ring_buffer_top: mismatch");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_phases();
		test_output_stall();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d requests: writes, reads, skips and clears,",
			results_checked, requests_sent);
		$display("capacities from 0 to 511, full and empty buffers, clipped bursts, stalls.");
		if (errors == 0) begin
			$display("byte_ring_buffer_top: match");
		end else begin
			$display("byte_ring_buffer_top: mismatch");
		end
		$finish;
	end

endmodule
